FILE: sv/sts_pkg.sv
// Shared types and constants for the sorted-table binary search block.
`default_nettype none

package sts_pkg;

  // Table geometry and value format.
  localparam int TABLE_DEPTH = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = IDX_W + 1;

  // Operation codes carried by an input item.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // One input item.
  typedef struct packed {
    logic                          operation;
    logic [IDX_W-1:0]              load_index;
    logic signed [VALUE_WIDTH-1:0] load_value;
    logic signed [VALUE_WIDTH-1:0] search_key;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr;     // store the input item's value in the table
    logic start;  // capture key and initial search range
    logic issue;  // read the table at the midpoint
    logic check;  // compare the read entry and narrow the range
    logic emit;   // move the result into the output register
  } sts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_empty;  // no entries left to probe
    logic equal;        // the read entry equals the key
    logic out_free;     // the output register can take a result
  } sts_stat_t;

endpackage

`default_nettype wire

FILE: sv/sorted_table_binary_search_top.sv
// Load transfer: stored in the transfer cycle with no result; in_ready stays high.
// Search transfer: each probe reads the table at the midpoint, then compares; an empty
// range ends the search without a match. The result then waits to load the output register,
// and in_ready stays low until it is loaded, so a search must finish before the next item
// is taken. A full output register holds the result back.
// Synchronous active-low reset clears table_size, the controller and out_valid, not the table.
`default_nettype none

module sorted_table_binary_search_top
  import sts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [SIZE_W-1:0] cfg_wdata
);

  sts_cmd_t  cmd;
  sts_stat_t stat;

  // Sequencer for loads and probes.
  sts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Table, range registers and result register.
  sts_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: sv/sts_datapath.sv
// Datapath: table memory, search range registers, comparator and output register.
`default_nettype none

module sts_datapath
  import sts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire in_item_t    in_data,
  input  wire logic        cfg_we,
  input  wire logic [SIZE_W-1:0] cfg_wdata,
  input  wire sts_cmd_t    cmd,
  output sts_stat_t        stat,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data
);

  logic signed [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
  logic signed [VALUE_WIDTH-1:0] rd_data_r;
  logic signed [VALUE_WIDTH-1:0] key_r;
  logic [SIZE_W-1:0]             table_size_r;
  logic [SIZE_W-1:0]             lo_r, lo_nxt;
  logic [SIZE_W-1:0]             hx_r, hx_nxt;   // exclusive upper bound
  logic [IDX_W-1:0]              mid_r;
  logic [IDX_W-1:0]              mid;
  logic [SIZE_W-1:0]             span;
  logic [SIZE_W-1:0]             size_clamped;
  logic                          hit_r, hit_nxt;
  logic                          out_valid_r, out_valid_nxt;
  out_item_t                     out_data_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= '0;
    end else if (cfg_we) begin
      table_size_r <= cfg_wdata;
    end
  end

  // A size above the table depth searches the whole table.
  assign size_clamped = (table_size_r > SIZE_W'(TABLE_DEPTH)) ?
                        SIZE_W'(TABLE_DEPTH) : table_size_r;

  // Midpoint of the open range: lo + floor((hi - lo) / 2), hi = hx - 1.
  assign span = hx_r - SIZE_W'(1) - lo_r;
  always_comb begin
    logic [SIZE_W-1:0] mid_full;
    mid_full = lo_r + (span >> 1);
    mid      = mid_full[IDX_W-1:0];
  end

  // Table memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[in_data.load_index] <= in_data.load_value;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[mid];
    end
  end

  // Range set on start and narrowed after each compare.
  always_comb begin
    lo_nxt  = lo_r;
    hx_nxt  = hx_r;
    hit_nxt = hit_r;
    if (cmd.start) begin
      lo_nxt  = '0;
      hx_nxt  = size_clamped;
      hit_nxt = 1'b0;
    end else if (cmd.check) begin
      if (rd_data_r == key_r) begin
        hit_nxt = 1'b1;
      end else if (rd_data_r > key_r) begin
        hx_nxt = {1'b0, mid_r};
      end else begin
        lo_nxt = {1'b0, mid_r} + SIZE_W'(1);
      end
    end
  end

  // Search registers.
  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hx_r  <= hx_nxt;
    hit_r <= hit_nxt;
    if (cmd.start) begin
      key_r <= in_data.search_key;
    end
    if (cmd.issue) begin
      mid_r <= mid;
    end
  end

  // Output register: filled on emit, emptied by a transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.emit) begin
      out_data_r.found       <= hit_r;
      out_data_r.match_index <= hit_r ? mid_r : '0;
    end
  end

  assign stat.range_empty = (lo_r >= hx_r);
  assign stat.equal       = (rd_data_r == key_r);
  assign stat.out_free    = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;

endmodule

`default_nettype wire

FILE: sv/sts_ctrl.sv
// Controller: sequences loads and the probe loop of a search.
`default_nettype none

module sts_ctrl
  import sts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_op,
  output logic           in_ready,
  input  wire sts_stat_t stat,
  output sts_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_CHECK,
    ST_FINISH
  } state_t;

  state_t st_r, st_nxt;

  // Next state and commands.
  always_comb begin
    st_nxt = st_r;
    cmd    = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_LOAD) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.start = 1'b1;
            st_nxt    = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        if (stat.range_empty) begin
          st_nxt = ST_FINISH;
        end else begin
          cmd.issue = 1'b1;
          st_nxt    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        st_nxt    = stat.equal ? ST_FINISH : ST_ISSUE;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign in_ready = (st_r == ST_IDLE);

`ifndef SYNTHESIS
  // A compare always follows a table read.
  a_check_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CHECK) |-> ($past(st_r) == ST_ISSUE))
    else $error("compare without a preceding table read");

  // A search transfer always enters the probe loop.
  a_start_to_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (st_r == ST_ISSUE))
    else $error("search did not enter the probe loop");

  // A finished result waits while the output register is full.
  a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_FINISH) && !stat.out_free) |=> (st_r == ST_FINISH))
    else $error("result dropped while output was full");

  // Loads are taken only when idle.
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> (in_ready && !cmd.start))
    else $error("table write outside idle");
`endif

endmodule

`default_nettype wire

FILE: tb/sorted_table_binary_search_top_tb.sv
// Self-checking testbench for the sorted-table binary search block.
`default_nettype none

module sorted_table_binary_search_top_tb
  import sts_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1200;
  localparam int MODE_B_AT   = 400;
  localparam int MODE_C_AT   = 800;
  // Longest search plus output register, with margin.
  localparam int DRAIN       = 24;

  localparam logic [VALUE_WIDTH-1:0] V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  // One row of the directed table.
  typedef struct {
    bit               set_size;
    logic [SIZE_W-1:0] size_val;
    in_item_t         item;
    bit               typed;
    out_item_t        want;
  } dir_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_we    = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  // Testbench copy of the block's state.
  logic signed [VALUE_WIDTH-1:0] table_copy [TABLE_DEPTH];
  logic [SIZE_W-1:0]             table_size_q = '0;
  out_item_t                     pending_results [$];

  int tx_idle_pct = 27;
  int rx_idle_pct = 64;
  int n_items     = 0;
  int n_loads     = 0;
  int n_searches  = 0;
  int n_hits      = 0;
  int n_sizes     = 0;
  int n_err       = 0;

  sorted_table_binary_search_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random, at a rate set by the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Binary search over the leading table entries, as the block should do it.
  function automatic out_item_t search_table(logic signed [VALUE_WIDTH-1:0] key);
    int        lo;
    int        hi;
    int        mid;
    int        span;
    out_item_t r;
    r    = '0;
    span = int'(table_size_q);
    if (span > TABLE_DEPTH) span = TABLE_DEPTH;
    lo = 0;
    hi = span - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (table_copy[mid] == key) begin
        r.found       = 1'b1;
        r.match_index = mid[IDX_W-1:0];
        return r;
      end else if (table_copy[mid] > key) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return r;
  endfunction

  function automatic in_item_t mk_item(logic op, int unsigned idx,
                                       logic [VALUE_WIDTH-1:0] val,
                                       logic [VALUE_WIDTH-1:0] key);
    in_item_t it;
    it.operation  = op;
    it.load_index = idx[IDX_W-1:0];
    it.load_value = val;
    it.search_key = key;
    return it;
  endfunction

  // Book-keeping for one accepted input transfer.
  function automatic void take_item(in_item_t it, bit typed, out_item_t want);
    if (it.operation == OP_LOAD) begin
      table_copy[it.load_index] = it.load_value;
      n_loads++;
    end else begin
      pending_results.push_back(typed ? want : search_table(it.search_key));
      n_searches++;
    end
    n_items++;
    // Swap the stall mix, then drop stalls altogether.
    if (n_items == MODE_B_AT) begin
      tx_idle_pct = 64;
      rx_idle_pct = 27;
    end else if (n_items == MODE_C_AT) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endfunction

  // Offer one item, with optional idle cycles first, and wait for its transfer.
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    take_item(it, typed, want);
  endtask

  // Write table_size once the block has gone quiet.
  task automatic set_table_size(int size);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // A trailing load gives no result, so let it finish as well.
    repeat (DRAIN) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= size[SIZE_W-1:0];
    @(posedge clk);
    cfg_we       <= 1'b0;
    table_size_q  = size[SIZE_W-1:0];
    n_sizes++;
  endtask

  // Load entries 0 .. n-1 with ascending values, either dense with repeats
  // or spread over the whole signed range.
  task automatic fill_sorted(int n);
    longint      cur;
    int unsigned lim;
    bit          dense;
    out_item_t   none;
    none  = '0;
    dense = $urandom_range(1);
    lim   = 32'hFFFF_FFFF / (n + 1);
    if (dense) cur = longint'($urandom_range(200)) - 100;
    else cur = -64'sd2147483648 + longint'($urandom_range(lim));
    for (int i = 0; i < n; i++) begin
      send_item(mk_item(OP_LOAD, i, cur[VALUE_WIDTH-1:0], $urandom), 1'b0, none);
      cur += dense ? longint'($urandom_range(2)) : longint'($urandom_range(lim));
    end
  endtask

  // Searches aimed at table contents and their neighbors, with some random
  // keys and a few stray loads that may break the ordering.
  task automatic search_batch(int span, int count);
    logic [VALUE_WIDTH-1:0] key;
    logic [VALUE_WIDTH-1:0] pick;
    int                     r;
    out_item_t              none;
    none = '0;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 10) begin
        send_item(mk_item(OP_LOAD, $urandom_range(TABLE_DEPTH - 1), $urandom, $urandom),
                  1'b0, none);
      end else begin
        pick = (span > 0) ? table_copy[$urandom_range(span - 1)] : $urandom;
        if (r < 55) key = pick;
        else if (r < 70) key = pick + 1;
        else if (r < 80) key = pick - 1;
        else if (r < 85) key = $urandom_range(1) ? V_MIN : V_MAX;
        else key = $urandom;
        send_item(mk_item(OP_SEARCH, $urandom_range(TABLE_DEPTH - 1), $urandom, key),
                  1'b0, none);
      end
    end
  endtask

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : result_check
    out_item_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        n_err++;
        $display("%0t: result with nothing expected: found=%0b index=%0d",
                 $time, out_data.found, out_data.match_index);
      end else begin
        w = pending_results.pop_front();
        if (out_data.found !== w.found) begin
          n_err++;
          $display("%0t: found mismatch: expected %0b, got %0b",
                   $time, w.found, out_data.found);
        end
        if (out_data.match_index !== w.match_index) begin
          n_err++;
          $display("%0t: match_index mismatch: expected %0d, got %0d",
                   $time, w.match_index, out_data.match_index);
        end
        if (out_data.found === 1'b1) n_hits++;
      end
    end
  end

  // Directed table of stimulus.
  dir_row_t plan [$];

  function automatic void add_row(bit set_size, int size_val, in_item_t it,
                                  bit typed, bit f, int mi);
    dir_row_t row;
    row.set_size          = set_size;
    row.size_val          = size_val[SIZE_W-1:0];
    row.item              = it;
    row.typed             = typed;
    row.want.found        = f;
    row.want.match_index  = mi[IDX_W-1:0];
    plan.push_back(row);
  endfunction

  initial begin : stimulus
    int r;
    int size;
    int span;

    // Empty table right after reset.
    add_row(0, 0, mk_item(OP_SEARCH, 0, 0, 0), 1, 0, 0);
    add_row(0, 0, mk_item(OP_SEARCH, 0, 0, V_MAX), 1, 0, 0);
    // Eight sorted entries spanning the signed extremes.
    add_row(0, 0, mk_item(OP_LOAD, 0, V_MIN, 0), 0, 0, 0);
    add_row(0, 0, mk_item(OP_LOAD, 1, -1000, 0), 0, 0, 0);
    add_row(0, 0, mk_item(OP_LOAD, 2, -1, 0), 0, 0, 0);
    add_row(0, 0, mk_item(OP_LOAD, 3, 0, 0), 0, 0, 0);
    add_row(0, 0, mk_item(OP_LOAD, 4, 1, 0), 0, 0, 0);
    add_row(0, 0, mk_item(OP_LOAD, 5, 1000, 0), 0, 0, 0);
    add_row(0, 0, mk_item(OP_LOAD, 6, V_MAX - 1, 0), 0, 0, 0);
    add_row(0, 0, mk_item(OP_LOAD, 7, V_MAX, 0), 0, 0, 0);
    add_row(1, 8, mk_item(OP_SEARCH, 0, 0, V_MIN), 1, 1, 0);
    add_row(0, 0, mk_item(OP_SEARCH, 0, 0, V_MAX), 1, 1, 7);
    add_row(0, 0, mk_item(OP_SEARCH, 0, 0, 0), 1, 1, 3);
    add_row(0, 0, mk_item(OP_SEARCH, 0, 0, 2), 1, 0, 0);
    add_row(0, 0, mk_item(OP_SEARCH, 0, 0, -1), 0, 0, 0);
    add_row(0, 0, mk_item(OP_SEARCH, 0, 0, 1000), 0, 0, 0);
    // A single-entry table only ever probes entry zero.
    add_row(1, 1, mk_item(OP_SEARCH, 0, 0, V_MIN), 1, 1, 0);
    add_row(1, 1, mk_item(OP_SEARCH, 0, 0, 0), 1, 0, 0);
    // Top entry, then break the ordering and search the unsorted table.
    add_row(0, 0, mk_item(OP_LOAD, 255, 32'h55AA_55AA, 0), 0, 0, 0);
    add_row(0, 0, mk_item(OP_LOAD, 2, 5000, 0), 0, 0, 0);
    add_row(1, 8, mk_item(OP_SEARCH, 0, 0, 5000), 0, 0, 0);
    add_row(0, 0, mk_item(OP_SEARCH, 0, 0, -1000), 0, 0, 0);
    // Back to an empty table.
    add_row(1, 0, mk_item(OP_SEARCH, 0, 0, V_MIN), 1, 0, 0);

    // Hold synchronous reset, then release it.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].set_size) set_table_size(plan[i].size_val);
      send_item(plan[i].item, plan[i].typed, plan[i].want);
    end

    // Full table, then a size beyond the depth, which must clamp.
    set_table_size(TABLE_DEPTH);
    fill_sorted(TABLE_DEPTH);
    search_batch(TABLE_DEPTH, 40);
    set_table_size((1 << SIZE_W) - 1);
    search_batch(TABLE_DEPTH, 30);

    // Random phases. Every entry is loaded by now, so any size is safe;
    // small tables are often refilled with fresh sorted content.
    while (n_items < ITEM_TARGET) begin
      r = $urandom_range(99);
      if (r < 8) size = 0;
      else if (r < 14) size = TABLE_DEPTH;
      else size = $urandom_range(24, 1);
      set_table_size(size);
      span = (size > TABLE_DEPTH) ? TABLE_DEPTH : size;
      if (span > 0 && span <= 32 && $urandom_range(1)) fill_sorted(span);
      search_batch(span, $urandom_range(40, 8));
    end
    in_valid <= 1'b0;

    // Let the remaining results come out, bounded.
    for (int i = 0; i < 5000 && pending_results.size() != 0; i++) @(posedge clk);
    if (pending_results.size() != 0) begin
      n_err++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    repeat (DRAIN) @(posedge clk);

    $display("Ran %0d loads and %0d searches (%0d found) over %0d table_size writes,",
             n_loads, n_searches, n_hits, n_sizes);
    $display("with both stall mixes and a stretch of back-to-back transfers; %0d errors.",
             n_err);
    if (n_err == 0) begin
      $display("sorted_table_binary_search_top_tb: done, clean");
    end else begin
      $display("sorted_table_binary_search_top_tb: done, errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("sorted_table_binary_search_top_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
